// ----- rtl/global_max_pool_argmax_macros.svh -----
// ---------------------------------------------------------------------------
// Global max pooling with argmax: assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef GLOBAL_MAX_POOL_ARGMAX_MACROS_SVH
`define GLOBAL_MAX_POOL_ARGMAX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gmpa_pkg.sv -----
// ---------------------------------------------------------------------------
// Global max pooling with argmax: package
// Field widths, register indexes and default sizes shared by the project.
// ---------------------------------------------------------------------------
package gmpa_pkg;

  localparam int DEF_MAX_CHANNELS  = 1024;
  localparam int DEF_MAX_POSITIONS = 65536;

  localparam int VALUE_W    = 16;
  localparam int CHAN_W     = 10;
  localparam int POS_W      = 16;
  localparam int CH_REG_W   = 11;
  localparam int POS_REG_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS  = 2'd0,
    REG_POSITIONS = 2'd1
  } cfg_reg_t;

endpackage

// ----- rtl/gmpa_ifs.sv -----
// ---------------------------------------------------------------------------
// Global max pooling with argmax: channel interfaces
// Valid/ready channels for samples, pooled results and register writes.
// ---------------------------------------------------------------------------
interface gmpa_in_if import gmpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface gmpa_out_if import gmpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  channel;
  logic [VALUE_W-1:0] max_value;
  logic [POS_W-1:0]   max_position;
  logic               last_of_batch;

  modport source (output valid, output channel, output max_value, output max_position,
                  output last_of_batch, input ready);
  modport sink (input valid, input channel, input max_value, input max_position,
                input last_of_batch, output ready);
endinterface

interface gmpa_cfg_if import gmpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/global_max_pool_argmax.sv -----
// ---------------------------------------------------------------------------
// Global max pooling with argmax
// Per-channel running maximum and first position of the maximum over a batch.
// ---------------------------------------------------------------------------
// The block takes one sample word per cycle while input ready is high,
// channel fastest within each position, and keeps each channel's running
// maximum and its position in a single one-read, one-write memory of
// MAX_CHANNELS words. A sample is read as it is accepted and written back
// as it leaves stage 1, the last write forwarded so that consecutive
// samples of one channel see each other. A result word is registered as the
// last-position sample of its channel leaves stage 1; input ready drops only
// while it waits in the full output register. Register writes restart the
// batch; the user must make them only while idle (the block does not check).
// ---------------------------------------------------------------------------
module global_max_pool_argmax import gmpa_pkg::*; #(
  parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
  parameter int MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  gmpa_cfg_if.sink    cfg_ch,
  gmpa_in_if.sink     in_ch,
  gmpa_out_if.source  out_ch
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PC_W   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int WORD_W = VALUE_W + POS_W;

  logic [WORD_W-1:0] mem [MAX_CHANNELS];

  logic [CH_W-1:0]    nc_m1_r;
  logic [PC_W-1:0]    np_m1_r;
  logic [CH_W-1:0]    ch_cnt_r, ch_cnt_nxt;
  logic [PC_W-1:0]    pos_cnt_r, pos_cnt_nxt;

  logic               s1_valid_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic [PC_W-1:0]    s1_pos_r;
  logic               s1_first_r;
  logic               s1_emit_r;
  logic               s1_last_r;
  logic [VALUE_W-1:0] s1_value_r;
  logic [WORD_W-1:0]  rd_q_r;

  logic               fwd_valid_r;
  logic [CH_W-1:0]    fwd_addr_r;
  logic [WORD_W-1:0]  fwd_data_r;

  logic               out_valid_r;
  logic [CHAN_W-1:0]  out_channel_r;
  logic [VALUE_W-1:0] out_max_value_r;
  logic [POS_W-1:0]   out_max_position_r;
  logic               out_last_r;

  logic               s1_stall, s1_go, accept, cfg_wr, greater;
  logic [WORD_W-1:0]  cur_word, new_word;
  logic [31:0]        ch_req, ch_eff, pos_req, pos_eff;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  assign ch_req  = 32'(cfg_ch.data[CH_REG_W-1:0]);
  assign pos_req = 32'(cfg_ch.data[POS_REG_W-1:0]);

  always_comb begin
    if (ch_req == 32'd0) begin
      ch_eff = 32'd1;
    end else if (ch_req > 32'(MAX_CHANNELS)) begin
      ch_eff = 32'(MAX_CHANNELS);
    end else begin
      ch_eff = ch_req;
    end
    if (pos_req == 32'd0) begin
      pos_eff = 32'd1;
    end else if (pos_req > 32'(MAX_POSITIONS)) begin
      pos_eff = 32'(MAX_POSITIONS);
    end else begin
      pos_eff = pos_req;
    end
  end

  assign s1_stall    = s1_valid_r && s1_emit_r && out_valid_r && !out_ch.ready;
  assign s1_go       = s1_valid_r && !s1_stall;
  assign in_ch.ready = !s1_stall;
  assign accept      = in_ch.valid && !s1_stall;

  always_comb begin
    ch_cnt_nxt  = ch_cnt_r;
    pos_cnt_nxt = pos_cnt_r;
    if (accept) begin
      if (ch_cnt_r == nc_m1_r) begin
        ch_cnt_nxt = '0;
        if (pos_cnt_r == np_m1_r) begin
          pos_cnt_nxt = '0;
        end else begin
          pos_cnt_nxt = pos_cnt_r + PC_W'(1);
        end
      end else begin
        ch_cnt_nxt = ch_cnt_r + CH_W'(1);
      end
    end
  end

  assign cur_word = (fwd_valid_r && fwd_addr_r == s1_ch_r) ? fwd_data_r : rd_q_r;
  assign greater  = $signed(s1_value_r) > $signed(cur_word[WORD_W-1:POS_W]);
  assign new_word = (s1_first_r || greater) ? {s1_value_r, POS_W'(s1_pos_r)} : cur_word;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem[s1_ch_r] <= new_word;
    end
    if (accept) begin
      rd_q_r <= mem[ch_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_m1_r     <= '0;
      np_m1_r     <= '0;
      ch_cnt_r    <= '0;
      pos_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          REG_CHANNELS: begin
            nc_m1_r   <= CH_W'(ch_eff - 32'd1);
            ch_cnt_r  <= '0;
            pos_cnt_r <= '0;
          end
          REG_POSITIONS: begin
            np_m1_r   <= PC_W'(pos_eff - 32'd1);
            ch_cnt_r  <= '0;
            pos_cnt_r <= '0;
          end
          default: begin
            ch_cnt_r  <= ch_cnt_nxt;
            pos_cnt_r <= pos_cnt_nxt;
          end
        endcase
      end else begin
        ch_cnt_r  <= ch_cnt_nxt;
        pos_cnt_r <= pos_cnt_nxt;
      end
      s1_valid_r <= s1_stall || accept;
      if (s1_go) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_go && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r    <= ch_cnt_r;
      s1_pos_r   <= pos_cnt_r;
      s1_first_r <= (pos_cnt_r == '0);
      s1_emit_r  <= (pos_cnt_r == np_m1_r);
      s1_last_r  <= (ch_cnt_r == nc_m1_r);
      s1_value_r <= in_ch.value;
    end
    if (s1_go) begin
      fwd_addr_r <= s1_ch_r;
      fwd_data_r <= new_word;
    end
    if (s1_go && s1_emit_r) begin
      out_channel_r      <= CHAN_W'(s1_ch_r);
      out_max_value_r    <= new_word[WORD_W-1:POS_W];
      out_max_position_r <= new_word[POS_W-1:0];
      out_last_r         <= s1_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel       = out_channel_r;
  assign out_ch.max_value     = out_max_value_r;
  assign out_ch.max_position  = out_max_position_r;
  assign out_ch.last_of_batch = out_last_r;

endmodule

// ----- rtl/gmpa_checker.sv -----
// ---------------------------------------------------------------------------
// Global max pooling with argmax: port checker
// Timing rules seen on the top-level ports, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "global_max_pool_argmax_macros.svh"

module gmpa_checker import gmpa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CHAN_W-1:0]  out_channel,
  input logic [VALUE_W-1:0] out_max_value,
  input logic [POS_W-1:0]   out_max_position,
  input logic               out_last_of_batch
);

  logic in_fire;

  assign in_fire = in_valid && in_ready;

  `GMPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(out_max_value) && $stable(out_max_position) && $stable(out_last_of_batch), "Stalled result word changed")
  `GMPA_ASSERT_NOW(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready, "Register write was not taken at once")
  `GMPA_ASSERT_NOW(a_in_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "Input stalled without a waiting result")
  `GMPA_ASSERT_NOW(a_out_latency, clk, rst_n, $rose(out_valid), $past(in_fire, 2), "Result word without a sample two cycles before")

endmodule

bind global_max_pool_argmax gmpa_checker u_gmpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_valid         (cfg_ch.valid),
  .cfg_ready         (cfg_ch.ready),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_channel       (out_ch.channel),
  .out_max_value     (out_ch.max_value),
  .out_max_position  (out_ch.max_position),
  .out_last_of_batch (out_ch.last_of_batch)
);
